FILE: sv/wasm_control_stack_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the structured control stack unit
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef WASM_CONTROL_STACK_UNIT_MACROS_SVH
`define WASM_CONTROL_STACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define WCSU_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("control stack unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define WCSU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("control stack unit: next-cycle check failed");

`endif

FILE: sv/wcsu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Control stack unit package
// Operation and status codes, block kinds and the frame stack control bundle.
// ---------------------------------------------------------------------------
package wcsu_pkg;

	typedef enum logic [2:0] {
		OP_CALL    = 3'd0,
		OP_INIT    = 3'd1,
		OP_UNREACH = 3'd2,
		OP_NOP     = 3'd3,
		OP_BLOCK   = 3'd4,
		OP_IF      = 3'd5,
		OP_ELSE    = 3'd6,
		OP_END     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_CONTINUE = 3'd0,
		ST_FINISHED = 3'd1,
		ST_TRAP     = 3'd2,
		ST_EXHAUST  = 3'd3,
		ST_MISMATCH = 3'd4
	} status_t;

	localparam logic [1:0] KIND_FUNC = 2'd0;
	localparam logic [1:0] KIND_INIT = 2'd1;

	// Frame stack request for one transfer
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

endpackage

FILE: sv/wcsu_frame_stack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Control frame stack
// Frame memory plus a register holding the top frame. Push writes the frame
// into memory and the top register; pop reloads the top from the entry below.
// ---------------------------------------------------------------------------
module wcsu_frame_stack #(
	parameter int FRAME_DEPTH    = 64,
	parameter int CODE_ADDR_BITS = 24,
	parameter int IDX_BITS       = 17
) (
	input  logic                                  clk,
	input  wcsu_pkg::stk_ctl_t                    ctl,
	input  logic [$clog2(FRAME_DEPTH+1)-1:0]      count,
	input  logic signed [IDX_BITS-1:0]            wr_saved_sp,
	input  logic signed [IDX_BITS-1:0]            wr_saved_fp,
	input  logic [CODE_ADDR_BITS-1:0]             wr_return_pc,
	input  logic [1:0]                            wr_kind,
	input  logic                                  wr_has_result,
	input  logic [7:0]                            wr_result_type,
	input  logic [CODE_ADDR_BITS-1:0]             wr_end_addr,
	output logic signed [IDX_BITS-1:0]            top_saved_sp,
	output logic signed [IDX_BITS-1:0]            top_saved_fp,
	output logic [CODE_ADDR_BITS-1:0]             top_return_pc,
	output logic [1:0]                            top_kind,
	output logic                                  top_has_result,
	output logic [7:0]                            top_result_type,
	output logic [CODE_ADDR_BITS-1:0]             top_end_addr
);
	import wcsu_pkg::*;

	localparam int CW = $clog2(FRAME_DEPTH + 1);
	localparam int IW = $clog2(FRAME_DEPTH);
	localparam int FW = 2 * IDX_BITS + 2 * CODE_ADDR_BITS + 11;

	logic [FW-1:0] mem [FRAME_DEPTH];
	logic [FW-1:0] top_q;
	logic [FW-1:0] wr_frame;
	logic [CW-1:0] below_cnt;
	logic [IW-1:0] wr_idx;
	logic [IW-1:0] rd_idx;

	assign wr_frame = {wr_saved_sp, wr_saved_fp, wr_return_pc, wr_end_addr,
		wr_result_type, wr_has_result, wr_kind};
	assign below_cnt = count - CW'(2);
	assign wr_idx = count[IW-1:0];
	assign rd_idx = below_cnt[IW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_idx] <= wr_frame;
		end
	end

	// Top frame: take the pushed frame, or fetch the one below on pop
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			top_q <= wr_frame;
		end else if (ctl.pop) begin
			top_q <= mem[rd_idx];
		end
	end

	assign {top_saved_sp, top_saved_fp, top_return_pc, top_end_addr,
		top_result_type, top_has_result, top_kind} = top_q;

endmodule

FILE: sv/wasm_control_stack_unit.sv
`timescale 1ns / 1ps
`include "wasm_control_stack_unit_macros.svh"
// ---------------------------------------------------------------------------
// WebAssembly structured control stack unit
// Executes decoded control operations against a frame stack, tracking pc,
// operand stack top and frame base, one operation per transfer.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | opcode, next_pc, block descriptor, top
//  output  | out_valid / out_ready| status, pc_out, sp_out, fp_out, move, depth
//
//  The input register feeds the execute logic, which loads the result
//  register when that register is free. Throughput is one operation per
//  cycle while the output is not stalled; the frame stack commits at the
//  cycle the result register loads, so the next operation sees it at once.
//  Only the top frame is read, from a register; a pop refills it from the
//  frame memory port in the same cycle.
//  Reset clears pc and frame base to zero, sp to -1 and the depth to zero;
//  frame memory is not cleared. A stalled output holds one result while one
//  more operation waits in the input register.
//
module wasm_control_stack_unit #(
	parameter int FRAME_DEPTH    = 64,
	parameter int CODE_ADDR_BITS = 24,
	parameter int OPERAND_DEPTH  = 65536
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [2:0]                                 opcode,
	input  logic [CODE_ADDR_BITS-1:0]                  next_pc,
	input  logic [1:0]                                 block_kind,
	input  logic                                       has_result,
	input  logic [7:0]                                 result_type,
	input  logic [CODE_ADDR_BITS-1:0]                  else_target,
	input  logic [CODE_ADDR_BITS-1:0]                  end_addr,
	input  logic [7:0]                                 num_params,
	input  logic [7:0]                                 num_locals,
	input  logic [7:0]                                 top_type,
	input  logic [31:0]                                top_value,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [2:0]                                 status,
	output logic [CODE_ADDR_BITS-1:0]                  pc_out,
	output logic signed [$clog2(OPERAND_DEPTH):0]      sp_out,
	output logic signed [$clog2(OPERAND_DEPTH):0]      fp_out,
	output logic                                       move_result,
	output logic [$clog2(FRAME_DEPTH+1)-1:0]           depth_out
);
	import wcsu_pkg::*;

	localparam int AW = CODE_ADDR_BITS;
	localparam int SW = $clog2(OPERAND_DEPTH) + 1;
	localparam int EW = SW + 10;
	localparam int CW = $clog2(FRAME_DEPTH + 1);
	localparam logic signed [EW-1:0] IDX_LO = -1;
	localparam logic signed [EW-1:0] IDX_HI = EW'(OPERAND_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(FRAME_DEPTH);

	// Saturate an index to the operand stack range
	function automatic logic signed [SW-1:0] clamp_idx(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] r;
		r = v;
		if (v < IDX_LO) begin
			r = IDX_LO;
		end else if (v > IDX_HI) begin
			r = IDX_HI;
		end
		return SW'(r);
	endfunction

	// Input register
	logic              valid_s1;
	op_t               op_s1;
	logic [AW-1:0]     npc_s1;
	logic [1:0]        kind_s1;
	logic              has_res_s1;
	logic [7:0]        rtype_s1;
	logic [AW-1:0]     else_s1;
	logic [AW-1:0]     end_s1;
	logic [7:0]        params_s1;
	logic [7:0]        locals_s1;
	logic [7:0]        ttype_s1;
	logic [31:0]       tval_s1;

	// Architectural state
	logic [AW-1:0]         pc_q;
	logic signed [SW-1:0]  sp_q;
	logic signed [SW-1:0]  fp_q;
	logic [CW-1:0]         cnt_q;

	// Result register
	logic                  out_valid_q;
	status_t               status_q;
	logic [AW-1:0]         pc_out_q;
	logic signed [SW-1:0]  sp_out_q;
	logic signed [SW-1:0]  fp_out_q;
	logic                  move_q;
	logic [CW-1:0]         depth_q;

	// Top frame from the stack
	logic signed [SW-1:0]  top_ssp;
	logic signed [SW-1:0]  top_sfp;
	logic [AW-1:0]         top_rpc;
	logic [1:0]            top_kind;
	logic                  top_has_res;
	logic [7:0]            top_rtype;
	logic [AW-1:0]         top_end;

	// Execute results
	status_t               st_nx;
	logic [AW-1:0]         pc_nx;
	logic signed [SW-1:0]  sp_nx;
	logic signed [SW-1:0]  fp_nx;
	logic [CW-1:0]         cnt_nx;
	logic                  move_nx;
	logic                  push_nx;
	logic                  pop_nx;
	logic signed [SW-1:0]  wr_ssp;
	logic [AW-1:0]         wr_rpc;
	logic signed [EW-1:0]  base_e;
	logic                  full;
	stk_ctl_t              stk_ctl;

	logic advance;
	logic fire;

	// The result register frees when empty or taken; the input register
	// frees when its operation moves into the result register.
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= op_t'(opcode);
			npc_s1     <= next_pc;
			kind_s1    <= block_kind;
			has_res_s1 <= has_result;
			rtype_s1   <= result_type;
			else_s1    <= else_target;
			end_s1     <= end_addr;
			params_s1  <= num_params;
			locals_s1  <= num_locals;
			ttype_s1   <= top_type;
			tval_s1    <= top_value;
		end
	end

	assign full   = (cnt_q == CNT_FULL);
	assign base_e = EW'(sp_q) - EW'($signed({1'b0, params_s1}));

	// Execute one control operation against the current state
	always_comb begin
		st_nx   = ST_CONTINUE;
		pc_nx   = npc_s1;
		sp_nx   = sp_q;
		fp_nx   = fp_q;
		cnt_nx  = cnt_q;
		move_nx = 1'b0;
		push_nx = 1'b0;
		pop_nx  = 1'b0;
		wr_ssp  = sp_q;
		wr_rpc  = npc_s1;
		unique case (op_s1)
			OP_CALL: begin
				if (full) begin
					st_nx = ST_EXHAUST;
				end else begin
					// Parameters become part of the callee frame
					push_nx = 1'b1;
					wr_ssp  = clamp_idx(base_e);
					wr_rpc  = pc_q;
					fp_nx   = clamp_idx(base_e + EW'(1));
					sp_nx   = clamp_idx(EW'(sp_q) + EW'($signed({1'b0, locals_s1})));
				end
			end
			OP_INIT, OP_BLOCK: begin
				if (full) begin
					st_nx = ST_EXHAUST;
				end else begin
					push_nx = 1'b1;
				end
			end
			OP_UNREACH: begin
				st_nx = ST_TRAP;
			end
			OP_NOP: begin
				st_nx = ST_CONTINUE;
			end
			OP_IF: begin
				if (full) begin
					st_nx = ST_EXHAUST;
				end else begin
					// Drop the condition before saving sp
					sp_nx  = clamp_idx(EW'(sp_q) - EW'(1));
					wr_ssp = sp_nx;
					if (tval_s1 == 32'd0 && else_s1 == '0) begin
						pc_nx = end_s1 + AW'(1);
					end else begin
						push_nx = 1'b1;
						if (tval_s1 == 32'd0) begin
							pc_nx = else_s1;
						end
					end
				end
			end
			OP_ELSE: begin
				if (cnt_q != '0) begin
					pc_nx = top_end;
				end
			end
			OP_END: begin
				if (cnt_q == '0) begin
					st_nx = ST_FINISHED;
				end else begin
					pop_nx = 1'b1;
					cnt_nx = cnt_q - CW'(1);
					if (top_has_res && ttype_s1 != top_rtype) begin
						st_nx = ST_MISMATCH;
					end else begin
						if (top_ssp < sp_q) begin
							if (top_has_res) begin
								move_nx = 1'b1;
								sp_nx   = clamp_idx(EW'(top_ssp) + EW'(1));
							end else begin
								sp_nx = top_ssp;
							end
						end
						fp_nx = top_sfp;
						if (top_kind == KIND_FUNC) begin
							pc_nx = top_rpc;
							if (cnt_nx == '0) begin
								st_nx = ST_FINISHED;
							end
						end else if (top_kind == KIND_INIT) begin
							st_nx = ST_FINISHED;
						end
					end
				end
			end
			default: begin
				st_nx = ST_CONTINUE;
			end
		endcase
		if (push_nx) begin
			cnt_nx = cnt_q + CW'(1);
		end
	end

	assign stk_ctl.push = fire && push_nx;
	assign stk_ctl.pop  = fire && pop_nx;

	wcsu_frame_stack #(
		.FRAME_DEPTH   (FRAME_DEPTH),
		.CODE_ADDR_BITS(CODE_ADDR_BITS),
		.IDX_BITS      (SW)
	) u_frames (
		.clk            (clk),
		.ctl            (stk_ctl),
		.count          (cnt_q),
		.wr_saved_sp    (wr_ssp),
		.wr_saved_fp    (fp_q),
		.wr_return_pc   (wr_rpc),
		.wr_kind        (kind_s1),
		.wr_has_result  (has_res_s1),
		.wr_result_type (rtype_s1),
		.wr_end_addr    (end_s1),
		.top_saved_sp   (top_ssp),
		.top_saved_fp   (top_sfp),
		.top_return_pc  (top_rpc),
		.top_kind       (top_kind),
		.top_has_result (top_has_res),
		.top_result_type(top_rtype),
		.top_end_addr   (top_end)
	);

	// Commit state at the same edge the result loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			sp_q  <= '1;
			fp_q  <= '0;
			cnt_q <= '0;
		end else if (fire) begin
			pc_q  <= pc_nx;
			sp_q  <= sp_nx;
			fp_q  <= fp_nx;
			cnt_q <= cnt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= st_nx;
			pc_out_q <= pc_nx;
			sp_out_q <= sp_nx;
			fp_out_q <= fp_nx;
			move_q   <= move_nx;
			depth_q  <= cnt_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pc_out      = pc_out_q;
	assign sp_out      = sp_out_q;
	assign fp_out      = fp_out_q;
	assign move_result = move_q;
	assign depth_out   = depth_q;

	// Depth never passes the frame capacity
	`WCSU_ASSERT_IMPLIES(a_depth_bound, clk, arst_n, 1'b1, cnt_q <= CNT_FULL)
	// No push onto a full stack, no pop of an empty one
	`WCSU_ASSERT_IMPLIES(a_stack_guard, clk, arst_n, stk_ctl.push || stk_ctl.pop, (stk_ctl.push && cnt_q != CNT_FULL) || (stk_ctl.pop && cnt_q != '0))
	// A push grows the depth by exactly one
	`WCSU_ASSERT_NEXT(a_push_depth, clk, arst_n, stk_ctl.push, cnt_q == $past(cnt_q) + CW'(1))
	// A result move only comes with a completed end
	`WCSU_ASSERT_IMPLIES(a_move_status, clk, arst_n, out_valid_q && move_q, status_q == ST_CONTINUE || status_q == ST_FINISHED)

endmodule
